// File: sv/pfc_pkg.sv
// Package for the packet frame checker: item types, status codes, register
// indexes and CRC-32 constants. No dependencies; used by every module.
`default_nettype none

package pfc_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

    // Configuration register indexes
    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    // Input operation codes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_BYTE   = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_GOOD         = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC    = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE    = 3'd2;
    localparam logic [2:0] ST_CRC_MISMATCH = 3'd3;
    localparam logic [2:0] ST_STRAY        = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [31:0] header_magic;
        logic [15:0] header_type;
        logic [31:0] header_length;
        logic [31:0] header_crc;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] packet_type;
        logic [31:0] payload_length;
        logic [31:0] computed_crc;
    } t_out_item;

endpackage

`default_nettype wire

// File: sv/pfc_crc8.sv
// Byte-wide update of a reflected CRC-32 (one byte per call, no final inversion).
// Depends on pfc_pkg for the polynomial.
`default_nettype none

module pfc_crc8 (
    input  wire logic [31:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [31:0] o_crc
);
    import pfc_pkg::*;

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        // Eight LSB-first shift steps; synthesis folds them into an XOR net
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

// File: sv/packet_frame_check.sv
// Top level of the packet frame checker: input register, header/byte checking
// with CRC-32 update, result register. Depends on pfc_pkg and pfc_crc8.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one item per accept,
//   either a packet header (magic, type, length, expected CRC) or one payload
//   byte. Output channel (o_out_valid / i_out_stall / o_out_item): at most one
//   result per input item, in input order.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (magic word, maximum payload length). Write only while the block is idle.
//   Path: each item is held in the input register while it is checked; its
//   result is loaded into the result register, which drives o_out_valid.
//   Throughput: one item per cycle. The checking stage fires whenever the
//   result register is empty or being drained, so items flow back to back as
//   long as the receiver takes each result; while a finished result waits,
//   the input register takes one more item and then the input side stalls.
//   Stall: when the receiver holds i_out_stall with a result pending, the
//   checking stage halts, the input register fills and o_in_stall rises in
//   the same cycle; no item is lost or repeated.
//   Reset (synchronous, i_rst_n low): both registers empty, no packet in
//   progress, CRC at all ones, magic word 0, maximum length 1048576.
`default_nettype none

module packet_frame_check (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire pfc_pkg::t_in_item i_in_item,
    // output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output pfc_pkg::t_out_item     o_out_item
);
    import pfc_pkg::*;

    // configuration registers
    logic [31:0] r_magic;
    logic [31:0] r_max_len;

    // input register
    logic        r_in_valid;
    t_in_item    r_in;

    // packet state
    logic        r_in_payload;
    logic [31:0] r_bytes_left;
    logic [31:0] r_crc;
    logic [31:0] r_held_crc;
    logic [15:0] r_held_type;
    logic [31:0] r_held_len;

    // result register
    logic        r_out_valid;
    t_out_item   r_out;

    logic        fire;
    logic [31:0] crc_upd;

    logic        n_in_payload;
    logic [31:0] n_bytes_left;
    logic [31:0] n_crc;
    logic        n_hold;
    logic        n_res_valid;
    t_out_item   n_res;

    // Advance the checking stage when the result slot is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    pfc_crc8 u_crc8 (
        .i_crc  (r_crc),
        .i_byte (r_in.data_byte),
        .o_crc  (crc_upd)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= '0;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAGIC:   r_magic   <= i_cfg_data;
                REG_MAX_LEN: r_max_len <= i_cfg_data;
                default:     r_magic   <= r_magic;
            endcase
        end
    end

    // Input register: load whenever it is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Checking logic for the item in the input register
    always_comb begin
        n_in_payload = r_in_payload;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_hold       = 1'b0;
        n_res_valid  = 1'b0;
        n_res        = '0;

        if (r_in.operation == OP_HEADER) begin
            // A new header drops any packet in progress
            n_in_payload          = 1'b0;
            n_bytes_left          = '0;
            n_crc                 = CRC_INIT;
            n_res.packet_type     = r_in.header_type;
            n_res.payload_length  = r_in.header_length;
            if (r_in.header_magic != r_magic) begin
                n_res_valid  = 1'b1;
                n_res.status = ST_BAD_MAGIC;
            end else if (r_in.header_length > r_max_len) begin
                n_res_valid  = 1'b1;
                n_res.status = ST_TOO_LARGE;
            end else begin
                n_hold = 1'b1;
                if (r_in.header_length == '0) begin
                    // empty payload: good at once
                    n_res_valid  = 1'b1;
                    n_res.status = ST_GOOD;
                end else begin
                    n_in_payload = 1'b1;
                    n_bytes_left = r_in.header_length;
                end
            end
        end else if (!r_in_payload) begin
            n_res_valid  = 1'b1;
            n_res.status = ST_STRAY;
        end else begin
            n_crc        = crc_upd;
            n_bytes_left = r_bytes_left - 32'd1;
            if (r_bytes_left == 32'd1) begin
                // last byte: compare the inverted CRC and go idle
                n_res_valid          = 1'b1;
                n_res.computed_crc   = ~crc_upd;
                n_res.packet_type    = r_held_type;
                n_res.payload_length = r_held_len;
                n_res.status         = (~crc_upd == r_held_crc) ? ST_GOOD : ST_CRC_MISMATCH;
                n_in_payload         = 1'b0;
                n_crc                = CRC_INIT;
            end
        end
    end

    // Packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_bytes_left <= '0;
            r_crc        <= CRC_INIT;
        end else if (fire) begin
            r_in_payload <= n_in_payload;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_hold) begin
            r_held_crc  <= r_in.header_crc;
            r_held_type <= r_in.header_type;
            r_held_len  <= r_in.header_length;
        end
    end

    // Result register: drain on accept, load on a producing item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= n_res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A packet in progress always has bytes left to take
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_bytes_left != '0))
        else $error("payload pending with zero bytes left");

    // Between packets the CRC sits at its initial value
    a_crc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_payload |-> (r_crc == CRC_INIT))
        else $error("CRC not reset between packets");

    // A byte with no header pending yields a stray report next cycle
    a_stray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in.operation == OP_BYTE) && !r_in_payload)
            |=> (r_out_valid && (r_out.status == ST_STRAY)))
        else $error("stray byte not reported");

    // The stage only halts while a result is blocked at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without an output block");

endmodule

`default_nettype wire
